FILE: sv/lpbled_pkg.sv
// Shared types and constants for the long-press button LED controller.
// Holds the request payload structs, mode codes, register indexes and reset values.
// No dependencies.
package lpbled_pkg;

    localparam int MODE_W = 3;
    localparam int TIME_W = 32;
    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 2;

    // Button state machine codes
    localparam logic [MODE_W-1:0] MODE_IDLE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_HELD = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SAVE_PENDING = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SAVE_FLASH = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RESTORE_FLASH = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAVE_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_INTERVAL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_HOLD = 2'd3;

    localparam logic [CFG_W-1:0] HOLD_THRESHOLD_RST = 16'd3000;
    localparam logic [CFG_W-1:0] SAVE_THRESHOLD_RST = 16'd5000;
    localparam logic [CFG_W-1:0] POLL_INTERVAL_RST = 16'd100;
    localparam logic [CFG_W-1:0] CLIP_HOLD_RST = 16'd100;

    localparam int FLASH_DURATION_DEF = 500;
    localparam int BLINK_PERIOD_DEF = 250;
    localparam int FLASH_SLOTS = 6;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              button_level;
        logic              voice_active;
        logic              clip_event;
    } in_t;

    typedef struct packed {
        logic              led_on;
        logic              restore_request;
        logic              save_request;
        logic [MODE_W-1:0] mode;
    } out_t;

endpackage

FILE: sv/long_press_button_led_controller.sv
// Long-press button detector with LED driver: top level, single module.
// Depends on lpbled_pkg for payload structs, mode codes and register defaults.
//
// Usage:
//   Input channel (in_valid/in_stall/in_data): one request per poll of the
//   control loop, carrying the ms timestamp, raw button level, voice-active
//   flag and clip event. Output channel (out_valid/out_stall/out_data): one
//   result request per input request, in order: LED level, restore and save
//   pulses and the button mode after that poll.
//   Config port: cfg_write/cfg_index/cfg_data writes one 16-bit register per
//   cycle; write only while no request is in flight.
// Pipeline and throughput:
//   Three register stages (input, state update plus reciprocal multiply,
//   remainder fix-up and LED select). A request passes the input register,
//   the stage 2 register and the output register in turn; one request per
//   cycle is sustained while out_stall is low. The button state advances as
//   a request leaves the input stage, so polls chain with no gap.
// Reset:
//   rst_n clears all pipeline valids, puts the machine in idle with zeroed
//   timers and loads the register defaults. No clearing pass.
// Back-pressure:
//   When out_stall is high the pipeline fills and then raises in_stall;
//   stalled results hold their value.
module long_press_button_led_controller #(
    parameter int FLASH_DURATION = lpbled_pkg::FLASH_DURATION_DEF,
    parameter int BLINK_PERIOD = lpbled_pkg::BLINK_PERIOD_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  lpbled_pkg::in_t                     in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output lpbled_pkg::out_t                    out_data,
    input  logic                                cfg_write,
    input  logic [lpbled_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lpbled_pkg::CFG_W-1:0]        cfg_data
);

    localparam int TW = lpbled_pkg::TIME_W;
    localparam int MW = lpbled_pkg::MODE_W;
    localparam int CW = lpbled_pkg::CFG_W;

    localparam int BLINK_DIV = (BLINK_PERIOD == 0) ? 1 : BLINK_PERIOD;
    localparam int SLOT_DIV = (FLASH_DURATION / lpbled_pkg::FLASH_SLOTS == 0) ? 1 :
                              FLASH_DURATION / lpbled_pkg::FLASH_SLOTS;
    localparam logic [CW-1:0] BLINK_DIV_W = CW'(BLINK_DIV);
    localparam logic [CW-1:0] SLOT_DIV_W = CW'(SLOT_DIV);
    // floor((2^32-1)/d): estimate is exact or one low
    localparam logic [TW-1:0] BLINK_RECIP = TW'(64'hFFFF_FFFF / 64'(BLINK_DIV));
    localparam logic [TW-1:0] SLOT_RECIP = TW'(64'hFFFF_FFFF / 64'(SLOT_DIV));
    localparam logic [TW-1:0] FLASH_DUR_W = TW'(FLASH_DURATION);

    // Config registers
    logic [CW-1:0] hold_thr_reg;
    logic [CW-1:0] save_thr_reg;
    logic [CW-1:0] poll_int_reg;
    logic [CW-1:0] clip_hold_reg;

    // Button state
    logic [MW-1:0] mode_reg, mode_next;
    logic [TW-1:0] press_start_reg, press_start_next;
    logic [TW-1:0] flash_end_reg, flash_end_next;
    logic [TW-1:0] last_sample_reg, last_sample_next;
    logic          sampled_reg, sampled_next;
    logic [TW-1:0] clip_end_reg, clip_end_next;

    // Stage 1: input register
    logic            s1_valid_reg;
    lpbled_pkg::in_t s1_data_reg;

    // Stage 2: after state update and multiply
    logic          s2_valid_reg;
    logic [MW-1:0] s2_mode_reg;
    logic          s2_restore_reg;
    logic          s2_save_reg;
    logic          s2_force_reg;
    logic          s2_voice_reg;
    logic          s2_slot_reg;
    logic [TW-1:0] s2_x_reg;
    logic [TW-1:0] s2_q_reg;

    // Stage 3: output register
    logic             out_valid_reg;
    lpbled_pkg::out_t out_data_reg;

    logic s3_free, s2_free, s1_free, s1_fire, s2_fire;

    logic [TW-1:0]   now;
    logic [TW-1:0]   press_time;
    logic            restore_now, save_now, force_now, use_slot;
    logic [TW-1:0]   div_x, div_recip;
    logic [2*TW-1:0] div_prod;

    logic [CW-1:0]    fix_div;
    logic [TW+CW-1:0] fix_prod;
    logic [TW-1:0]    fix_rem;
    logic             quot_lsb;
    logic             led_next;

    // Handshake
    assign s3_free = !out_valid_reg || !out_stall;
    assign s2_free = !s2_valid_reg || s3_free;
    assign s1_free = !s1_valid_reg || s2_free;
    assign s1_fire = s1_valid_reg && s2_free;
    assign s2_fire = s2_valid_reg && s3_free;
    assign in_stall = !s1_free;
    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_thr_reg <= lpbled_pkg::HOLD_THRESHOLD_RST;
            save_thr_reg <= lpbled_pkg::SAVE_THRESHOLD_RST;
            poll_int_reg <= lpbled_pkg::POLL_INTERVAL_RST;
            clip_hold_reg <= lpbled_pkg::CLIP_HOLD_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                lpbled_pkg::CFG_HOLD_THRESHOLD: hold_thr_reg <= cfg_data;
                lpbled_pkg::CFG_SAVE_THRESHOLD: save_thr_reg <= cfg_data;
                lpbled_pkg::CFG_POLL_INTERVAL:  poll_int_reg <= cfg_data;
                lpbled_pkg::CFG_CLIP_HOLD:      clip_hold_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // State update for the request leaving stage 1
    assign now = s1_data_reg.now_ms;
    assign press_time = now - press_start_reg;

    always_comb
    begin
        last_sample_next = last_sample_reg;
        sampled_next = sampled_reg;
        if ((now - last_sample_reg) >= {{(TW-CW){1'b0}}, poll_int_reg})
        begin
            last_sample_next = now;
            sampled_next = s1_data_reg.button_level;
        end

        mode_next = mode_reg;
        press_start_next = press_start_reg;
        flash_end_next = flash_end_reg;
        restore_now = 1'b0;
        save_now = 1'b0;
        unique case (mode_reg)
            lpbled_pkg::MODE_IDLE:
            begin
                if (sampled_next)
                begin
                    press_start_next = now;
                    mode_next = lpbled_pkg::MODE_HELD;
                end
            end
            lpbled_pkg::MODE_HELD:
            begin
                if (!sampled_next)
                begin
                    restore_now = 1'b1;
                    flash_end_next = now + FLASH_DUR_W;
                    mode_next = lpbled_pkg::MODE_RESTORE_FLASH;
                end
                else if (press_time >= {{(TW-CW){1'b0}}, hold_thr_reg})
                begin
                    mode_next = lpbled_pkg::MODE_SAVE_PENDING;
                end
            end
            lpbled_pkg::MODE_SAVE_PENDING:
            begin
                if (!sampled_next)
                begin
                    mode_next = lpbled_pkg::MODE_IDLE;
                end
                else if (press_time >= {{(TW-CW){1'b0}}, save_thr_reg})
                begin
                    save_now = 1'b1;
                    flash_end_next = now + FLASH_DUR_W;
                    mode_next = lpbled_pkg::MODE_SAVE_FLASH;
                end
            end
            lpbled_pkg::MODE_SAVE_FLASH,
            lpbled_pkg::MODE_RESTORE_FLASH:
            begin
                if (now >= flash_end_reg)
                begin
                    mode_next = lpbled_pkg::MODE_IDLE;
                end
            end
            default:
            begin
                mode_next = lpbled_pkg::MODE_IDLE;
            end
        endcase

        clip_end_next = clip_end_reg;
        if (s1_data_reg.clip_event)
        begin
            clip_end_next = now + {{(TW-CW){1'b0}}, clip_hold_reg};
        end
        force_now = clip_end_next > now;
    end

    // Quotient estimate: save flash uses elapsed/slot, otherwise now/blink
    assign use_slot = (mode_next == lpbled_pkg::MODE_SAVE_FLASH);
    assign div_x = use_slot ? (now - (flash_end_next - FLASH_DUR_W)) : now;
    assign div_recip = use_slot ? SLOT_RECIP : BLINK_RECIP;
    assign div_prod = div_x * div_recip;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= lpbled_pkg::MODE_IDLE;
            press_start_reg <= '0;
            flash_end_reg <= '0;
            last_sample_reg <= '0;
            sampled_reg <= 1'b0;
            clip_end_reg <= '0;
        end
        else if (s1_fire)
        begin
            mode_reg <= mode_next;
            press_start_reg <= press_start_next;
            flash_end_reg <= flash_end_next;
            last_sample_reg <= last_sample_next;
            sampled_reg <= sampled_next;
            clip_end_reg <= clip_end_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_free)
        begin
            s1_data_reg <= in_data;
        end
        if (s1_fire)
        begin
            s2_mode_reg <= mode_next;
            s2_restore_reg <= restore_now;
            s2_save_reg <= save_now;
            s2_force_reg <= force_now;
            s2_voice_reg <= s1_data_reg.voice_active;
            s2_slot_reg <= use_slot;
            s2_x_reg <= div_x;
            s2_q_reg <= div_prod[2*TW-1:TW];
        end
        if (s2_fire)
        begin
            out_data_reg.led_on <= led_next;
            out_data_reg.restore_request <= s2_restore_reg;
            out_data_reg.save_request <= s2_save_reg;
            out_data_reg.mode <= s2_mode_reg;
        end
    end

    // Remainder check bumps the estimate by one when needed
    assign fix_div = s2_slot_reg ? SLOT_DIV_W : BLINK_DIV_W;
    assign fix_prod = s2_q_reg * fix_div;
    assign fix_rem = s2_x_reg - fix_prod[TW-1:0];
    assign quot_lsb = s2_q_reg[0] ^ (fix_rem >= {{(TW-CW){1'b0}}, fix_div});

    always_comb
    begin
        unique case (s2_mode_reg)
            lpbled_pkg::MODE_SAVE_PENDING,
            lpbled_pkg::MODE_SAVE_FLASH:    led_next = !quot_lsb;
            lpbled_pkg::MODE_RESTORE_FLASH: led_next = 1'b1;
            default:                        led_next = s2_voice_reg;
        endcase
        if (s2_force_reg)
        begin
            led_next = 1'b1;
        end
    end

`ifndef NO_ASSERTIONS
    a_req_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.restore_request && out_data.save_request))
        else $error("restore and save requested together");

    a_restore_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.restore_request |->
            out_data.mode == lpbled_pkg::MODE_RESTORE_FLASH)
        else $error("restore pulse outside restore flash");

    a_save_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.save_request |->
            out_data.mode == lpbled_pkg::MODE_SAVE_FLASH)
        else $error("save pulse outside save flash");

    a_restore_led: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.mode == lpbled_pkg::MODE_RESTORE_FLASH |-> out_data.led_on)
        else $error("LED off during restore flash");
`endif

endmodule

FILE: dv/lpbled_monitor.sv
// Passive monitor for the long-press button LED controller: tracks config writes,
// predicts the result of every accepted poll request and compares it with the output.
// Depends on lpbled_pkg for the request structs, mode codes and register indexes.
module lpbled_monitor #(
    parameter int FLASH_DUR = lpbled_pkg::FLASH_DURATION_DEF,
    parameter int BLINK = lpbled_pkg::BLINK_PERIOD_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  lpbled_pkg::in_t                     in_data,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  lpbled_pkg::out_t                    out_data,
    input  logic                                cfg_write,
    input  logic [lpbled_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lpbled_pkg::CFG_W-1:0]        cfg_data,
    output int                                  mismatch_count,
    output int                                  polls_in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] FLASH_LEN = FLASH_DUR;
    localparam logic [31:0] BLINK_DIV = (BLINK == 0) ? 1 : BLINK;
    localparam logic [31:0] SLOT_DIV =
        (FLASH_DUR / lpbled_pkg::FLASH_SLOTS == 0) ? 1 : FLASH_DUR / lpbled_pkg::FLASH_SLOTS;

    logic [lpbled_pkg::CFG_W-1:0]  thr_hold;
    logic [lpbled_pkg::CFG_W-1:0]  thr_save;
    logic [lpbled_pkg::CFG_W-1:0]  poll_ivl;
    logic [lpbled_pkg::CFG_W-1:0]  clip_hold;

    logic [lpbled_pkg::MODE_W-1:0] btn_mode;
    logic [31:0]                   press_t0;
    logic [31:0]                   flash_end;
    logic [31:0]                   last_sample;
    logic                          btn_sampled;
    logic [31:0]                   clip_end;

    lpbled_pkg::out_t              expected_leds[$];

    function automatic lpbled_pkg::out_t predict_poll(lpbled_pkg::in_t req);
        lpbled_pkg::out_t res;
        logic [31:0]      now;
        logic [31:0]      quot;
        logic             led;
        res = '0;
        now = req.now_ms;

        if (now - last_sample >= {16'h0, poll_ivl}) begin
            btn_sampled = req.button_level;
            last_sample = now;
        end

        case (btn_mode)
            lpbled_pkg::MODE_IDLE:
            begin
                if (btn_sampled)
                begin
                    press_t0 = now;
                    btn_mode = lpbled_pkg::MODE_HELD;
                end
            end
            lpbled_pkg::MODE_HELD:
            begin
                if (!btn_sampled)
                begin
                    res.restore_request = 1'b1;
                    flash_end = now + FLASH_LEN;
                    btn_mode = lpbled_pkg::MODE_RESTORE_FLASH;
                end
                else if (now - press_t0 >= {16'h0, thr_hold})
                begin
                    btn_mode = lpbled_pkg::MODE_SAVE_PENDING;
                end
            end
            lpbled_pkg::MODE_SAVE_PENDING:
            begin
                if (!btn_sampled)
                begin
                    btn_mode = lpbled_pkg::MODE_IDLE;
                end
                else if (now - press_t0 >= {16'h0, thr_save})
                begin
                    res.save_request = 1'b1;
                    flash_end = now + FLASH_LEN;
                    btn_mode = lpbled_pkg::MODE_SAVE_FLASH;
                end
            end
            lpbled_pkg::MODE_SAVE_FLASH, lpbled_pkg::MODE_RESTORE_FLASH:
            begin
                if (now >= flash_end)
                    btn_mode = lpbled_pkg::MODE_IDLE;
            end
            default:
            begin
                btn_mode = lpbled_pkg::MODE_IDLE;
            end
        endcase

        case (btn_mode)
            lpbled_pkg::MODE_SAVE_PENDING:
            begin
                quot = now / BLINK_DIV;
                led = ~quot[0];
            end
            lpbled_pkg::MODE_RESTORE_FLASH:
            begin
                led = 1'b1;
            end
            lpbled_pkg::MODE_SAVE_FLASH:
            begin
                // three pulses: even slots of the flash window are lit
                quot = (now - (flash_end - FLASH_LEN)) / SLOT_DIV;
                led = ~quot[0];
            end
            default:
            begin
                led = req.voice_active;
            end
        endcase

        // plain unsigned compare: an end time that wrapped ends at once
        if (req.clip_event)
            clip_end = now + {16'h0, clip_hold};
        if (clip_end > now)
            led = 1'b1;

        res.led_on = led;
        res.mode = btn_mode;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lpbled_pkg::out_t want;
        if (!rst_n)
        begin
            thr_hold = lpbled_pkg::HOLD_THRESHOLD_RST;
            thr_save = lpbled_pkg::SAVE_THRESHOLD_RST;
            poll_ivl = lpbled_pkg::POLL_INTERVAL_RST;
            clip_hold = lpbled_pkg::CLIP_HOLD_RST;
            btn_mode = lpbled_pkg::MODE_IDLE;
            press_t0 = '0;
            flash_end = '0;
            last_sample = '0;
            btn_sampled = 1'b0;
            clip_end = '0;
            expected_leds.delete();
            mismatch_count = 0;
            polls_in_flight = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    lpbled_pkg::CFG_HOLD_THRESHOLD: thr_hold = cfg_data;
                    lpbled_pkg::CFG_SAVE_THRESHOLD: thr_save = cfg_data;
                    lpbled_pkg::CFG_POLL_INTERVAL:  poll_ivl = cfg_data;
                    lpbled_pkg::CFG_CLIP_HOLD:      clip_hold = cfg_data;
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
                expected_leds.push_back(predict_poll(in_data));

            if (out_valid && !out_stall)
            begin
                if (expected_leds.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result request: led=%0b rst=%0b sav=%0b mode=%0d",
                                 out_data.led_on, out_data.restore_request,
                                 out_data.save_request, out_data.mode);
                end
                else
                begin
                    want = expected_leds.pop_front();
                    if (out_data.led_on !== want.led_on
                        || out_data.restore_request !== want.restore_request
                        || out_data.save_request !== want.save_request
                        || out_data.mode !== want.mode)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: exp led=%0b rst=%0b sav=%0b mode=%0d, %s%0b %s%0b %s%0b %s%0d",
                                     want.led_on, want.restore_request,
                                     want.save_request, want.mode,
                                     "got led=", out_data.led_on,
                                     "rst=", out_data.restore_request,
                                     "sav=", out_data.save_request,
                                     "mode=", out_data.mode);
                    end
                end
            end
            polls_in_flight = expected_leds.size();
        end
    end

endmodule

FILE: dv/tb_top.sv
// Testbench top for the long-press button LED controller: clock, reset, config
// writes, poll stimulus and output back-pressure; verdict from lpbled_monitor.
// Depends on lpbled_pkg, long_press_button_led_controller and lpbled_monitor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES = 12;
    localparam int PHASE_POLLS = 160;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    lpbled_pkg::in_t                  in_data = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    lpbled_pkg::out_t                 out_data;
    logic                             cfg_write = 1'b0;
    logic [lpbled_pkg::CFG_IDX_W-1:0] cfg_index = lpbled_pkg::CFG_HOLD_THRESHOLD;
    logic [lpbled_pkg::CFG_W-1:0]     cfg_data = '0;

    int                   mismatch_count;
    int                   polls_in_flight;
    int                   cycle_count = 0;
    int                   gap_max = 6;
    int                   stall_max = 6;
    int                   stall_left = 0;
    logic [31:0]          ms_now = '0;

    long_press_button_led_controller u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lpbled_monitor u_monitor (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_data        (out_data),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .polls_in_flight (polls_in_flight)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // output back-pressure: a fresh stall length is drawn after every accepted result
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            stall_left = $urandom_range(0, stall_max);
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    task automatic send_request(input lpbled_pkg::in_t req);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic poll(input logic [31:0] t, input logic level, input logic voice,
                        input logic clip);
        lpbled_pkg::in_t req;
        req.now_ms = t;
        req.button_level = level;
        req.voice_active = voice;
        req.clip_event = clip;
        send_request(req);
    endtask

    task automatic set_reg(input logic [lpbled_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lpbled_pkg::CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (polls_in_flight != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    initial
    begin
        int          sent;
        int          run_len;
        int          step_max;
        int          longest;
        logic [15:0] hold_v, save_v, poll_v, clip_v;
        logic        level;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at reset register values
        poll(32'd0, 1'b1, 1'b1, 1'b0);      // no sample before the first interval
        poll(32'd50, 1'b1, 1'b0, 1'b1);     // clip forces LED
        poll(32'd100, 1'b1, 1'b0, 1'b0);    // first sample -> held
        poll(32'd1100, 1'b1, 1'b1, 1'b0);
        poll(32'd3100, 1'b1, 1'b0, 1'b0);   // save pending
        poll(32'd3350, 1'b1, 1'b0, 1'b0);   // other blink phase
        poll(32'd5100, 1'b1, 1'b0, 1'b0);   // save request
        poll(32'd5200, 1'b1, 1'b0, 1'b0);
        poll(32'd5300, 1'b1, 1'b1, 1'b0);
        poll(32'd5600, 1'b0, 1'b0, 1'b0);   // flash over
        poll(32'd5700, 1'b1, 1'b0, 1'b0);
        poll(32'd5800, 1'b0, 1'b0, 1'b0);   // short press -> restore
        poll(32'd6000, 1'b0, 1'b0, 1'b0);
        poll(32'd6300, 1'b0, 1'b1, 1'b0);
        poll(32'd6320, 1'b1, 1'b1, 1'b1);   // pressed but not sampled yet
        poll(32'hFFFF_FF00, 1'b1, 1'b1, 1'b1);
        poll(32'hFFFF_FFF0, 1'b1, 1'b0, 1'b1); // clip end wraps: no force
        poll(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
        poll(32'h0000_0010, 1'b0, 1'b0, 1'b1);
        poll(32'h0000_0200, 1'b0, 1'b1, 1'b0); // press spans the time wrap -> restore
        poll(32'hAAAA_5555, 1'b1, 1'b0, 1'b0);
        poll(32'h5555_AAAA, 1'b0, 1'b1, 1'b1);
        ms_now = 32'h5555_AAAA;
        drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    hold_v = '0; save_v = '0; poll_v = '0; clip_v = '0;
                end
                1:
                begin
                    hold_v = '1; save_v = '1; poll_v = '1; clip_v = '1;
                end
                2:
                begin
                    hold_v = lpbled_pkg::HOLD_THRESHOLD_RST;
                    save_v = lpbled_pkg::SAVE_THRESHOLD_RST;
                    poll_v = lpbled_pkg::POLL_INTERVAL_RST;
                    clip_v = lpbled_pkg::CLIP_HOLD_RST;
                end
                7:
                begin
                    hold_v = 16'($urandom); save_v = 16'($urandom);
                    poll_v = 16'($urandom_range(0, 2000)); clip_v = 16'($urandom);
                end
                default:
                begin
                    hold_v = 16'($urandom_range(0, 800));
                    save_v = 16'($urandom_range(0, 1200));
                    poll_v = 16'($urandom_range(0, 60));
                    clip_v = 16'($urandom_range(0, 300));
                end
            endcase
            set_reg(lpbled_pkg::CFG_HOLD_THRESHOLD, hold_v);
            set_reg(lpbled_pkg::CFG_SAVE_THRESHOLD, save_v);
            set_reg(lpbled_pkg::CFG_POLL_INTERVAL, poll_v);
            set_reg(lpbled_pkg::CFG_CLIP_HOLD, clip_v);
            cfg_write <= 1'b0;

            gap_max = (ph % 3 == 1) ? 0 : 6;
            stall_max = (ph % 4 == 2) ? 0 : 6;
            longest = (hold_v > save_v) ? int'(hold_v) : int'(save_v);
            step_max = longest / 6 + int'(poll_v) + 8;
            if (ph % 5 == 3)
                ms_now = 32'hFFFF_FFFF - $urandom_range(0, 20000);

            sent = 0;
            while (sent < PHASE_POLLS)
            begin
                // mostly press-and-release runs, some noise
                run_len = $urandom_range(1, 24);
                for (int k = 0; k < run_len + 8; k++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        level = 1'($urandom_range(0, 1));
                    else if (k < run_len)
                        level = 1'b1;
                    else if (k < run_len + $urandom_range(1, 8))
                        level = 1'b0;
                    else
                        break;
                    if ($urandom_range(0, 63) == 0)
                        ms_now = $urandom;
                    else
                        ms_now = ms_now + $urandom_range(0, step_max);
                    poll(ms_now, level, 1'($urandom_range(0, 1)),
                         $urandom_range(0, 7) == 0);
                    sent++;
                end
            end
            drain();
        end

        if (mismatch_count == 0 && polls_in_flight == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
